### rtl/pcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and codes for the Pearson correlation unit.
// ----------------------------------------------------------------------------
package pcc_pkg;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic               last_pair;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] coefficient_q15;
    logic [1:0]         status;
    logic [16:0]        pair_count;
  } out_item_t;

  // Finished set handed from the accumulator to the solver.
  typedef struct packed {
    logic [16:0]        count;
    logic signed [32:0] sum_x;
    logic signed [32:0] sum_y;
    logic [46:0]        sum_xx;
    logic [46:0]        sum_yy;
    logic signed [47:0] sum_xy;
    logic               overflowed;
  } job_t;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_ZERO_VAR = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_LOAD,
    BK_MUL,
    BK_DIV,
    BK_SQRT,
    BK_DONE
  } bk_state_e;

  // Order of the products formed by the shared multiplier.
  typedef enum logic [2:0] {
    MO_NXX,
    MO_XX,
    MO_NYY,
    MO_YY,
    MO_NXY,
    MO_XY,
    MO_VAR,
    MO_NUM
  } mul_op_e;

endpackage

### rtl/pcc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_front
// Accumulate count and sums one pair per cycle while the job queue has room; hand off a job on last pair.
// ----------------------------------------------------------------------------
module pcc_front #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  pcc_pkg::in_item_t in_item_i,
  input  logic              q_full_i,
  output logic              push_o,
  output pcc_pkg::job_t     job_o
);

  localparam logic [16:0] MaxCnt = 17'(MAX_SAMPLES);

  logic [16:0]        count_q, count_d;
  logic signed [32:0] sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [46:0]        sum_xx_q, sum_xx_d, sum_yy_q, sum_yy_d;
  logic signed [47:0] sum_xy_q, sum_xy_d;
  logic               ovf_q, ovf_d;

  logic signed [SAMPLE_BITS-1:0]   xn, yn;
  logic signed [2*SAMPLE_BITS-1:0] xx, yy, xy;
  logic                            take;

  assign xn   = in_item_i.sample_x[SAMPLE_BITS-1:0];
  assign yn   = in_item_i.sample_y[SAMPLE_BITS-1:0];
  assign xx   = xn * xn;
  assign yy   = yn * yn;
  assign xy   = xn * yn;
  assign take = in_valid_i && !q_full_i;

  assign in_stall_o = q_full_i;

  always_comb begin
    count_d  = count_q;
    sum_x_d  = sum_x_q;
    sum_y_d  = sum_y_q;
    sum_xx_d = sum_xx_q;
    sum_yy_d = sum_yy_q;
    sum_xy_d = sum_xy_q;
    ovf_d    = ovf_q;
    if (take) begin
      if (count_q < MaxCnt) begin
        count_d  = count_q + 17'd1;
        sum_x_d  = sum_x_q + 33'(xn);
        sum_y_d  = sum_y_q + 33'(yn);
        sum_xx_d = sum_xx_q + 47'($unsigned(xx));
        sum_yy_d = sum_yy_q + 47'($unsigned(yy));
        sum_xy_d = sum_xy_q + 48'(xy);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  assign push_o           = take && in_item_i.last_pair;
  assign job_o.count      = count_d;
  assign job_o.sum_x      = sum_x_d;
  assign job_o.sum_y      = sum_y_d;
  assign job_o.sum_xx     = sum_xx_d;
  assign job_o.sum_yy     = sum_yy_d;
  assign job_o.sum_xy     = sum_xy_d;
  assign job_o.overflowed = ovf_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
      ovf_q    <= 1'b0;
    end else if (push_o) begin
      count_q  <= '0;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      sum_xx_q <= '0;
      sum_yy_q <= '0;
      sum_xy_q <= '0;
      ovf_q    <= 1'b0;
    end else begin
      count_q  <= count_d;
      sum_x_q  <= sum_x_d;
      sum_y_q  <= sum_y_d;
      sum_xx_q <= sum_xx_d;
      sum_yy_q <= sum_yy_d;
      sum_xy_q <= sum_xy_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

### rtl/pcc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_queue
// Two-entry job queue between accumulator and solver.
// ----------------------------------------------------------------------------
module pcc_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  pcc_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output pcc_pkg::job_t job_o
);

  pcc_pkg::job_t slot_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    fill_q;

  assign full_o  = fill_q == 2'd2;
  assign valid_o = fill_q != 2'd0;
  assign job_o   = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      fill_q <= fill_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/pcc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_back
// Solve one job: shift-add products, long division, bitwise square root.
// ----------------------------------------------------------------------------
module pcc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               job_valid_i,
  input  pcc_pkg::job_t      job_i,
  output logic               job_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pcc_pkg::out_item_t out_item_o
);

  pcc_pkg::bk_state_e state_q, state_d;
  pcc_pkg::mul_op_e   op_q, op_d;
  pcc_pkg::job_t      job_q;
  pcc_pkg::out_item_t out_q, out_d;

  logic [127:0]       mc_q, mc_d, acc_q, acc_d, t0_q, t0_d;
  logic [63:0]        mp_q, mp_d;
  logic [62:0]        dx_q, dx_d, dy_q, dy_d;
  logic signed [65:0] num_q, num_d;
  logic [159:0]       rem_q, rem_d, dv_q, dv_d;
  logic [30:0]        quo_q, quo_d;
  logic [15:0]        root_q, root_d;
  logic [4:0]         cnt_q, cnt_d;
  logic [1:0]         status_q, status_d;
  logic               out_vld_q, out_vld_d;

  logic [32:0]  sx_mag, sy_mag;
  logic [47:0]  sxy_mag;
  logic [62:0]  mag;
  logic [127:0] op_a;
  logic [63:0]  op_b;
  logic [65:0]  prod_s;
  logic         mul_done, rem_ge, zero_var, out_free, load_out;
  logic [15:0]  cand;
  logic [31:0]  cand_sq;

  assign sx_mag  = job_q.sum_x[32] ? (~job_q.sum_x + 33'd1) : job_q.sum_x;
  assign sy_mag  = job_q.sum_y[32] ? (~job_q.sum_y + 33'd1) : job_q.sum_y;
  assign sxy_mag = job_q.sum_xy[47] ? (~job_q.sum_xy + 48'd1) : job_q.sum_xy;
  assign mag     = num_q[65] ? 63'(-num_q) : num_q[62:0];

  assign mul_done = mp_q == 64'd0;
  assign rem_ge   = rem_q >= dv_q;
  assign zero_var = dx_q == 63'd0 || dy_q == 63'd0;
  assign out_free = !out_vld_q || !out_stall_i;
  assign cand     = root_q | (16'd1 << cnt_q[3:0]);
  assign cand_sq  = cand * cand;
  assign prod_s   = {1'b0, acc_q[64:0]};

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (op_q)
      pcc_pkg::MO_NXX: begin
        op_a = 128'(job_q.count);
        op_b = 64'(job_q.sum_xx);
      end
      pcc_pkg::MO_XX: begin
        op_a = 128'(sx_mag);
        op_b = 64'(sx_mag);
      end
      pcc_pkg::MO_NYY: begin
        op_a = 128'(job_q.count);
        op_b = 64'(job_q.sum_yy);
      end
      pcc_pkg::MO_YY: begin
        op_a = 128'(sy_mag);
        op_b = 64'(sy_mag);
      end
      pcc_pkg::MO_NXY: begin
        op_a = 128'(job_q.count);
        op_b = 64'(sxy_mag);
      end
      pcc_pkg::MO_XY: begin
        op_a = 128'(sx_mag);
        op_b = 64'(sy_mag);
      end
      pcc_pkg::MO_VAR: begin
        op_a = 128'(dx_q);
        op_b = 64'(dy_q);
      end
      pcc_pkg::MO_NUM: begin
        op_a = 128'(mag);
        op_b = 64'(mag);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pcc_pkg::BK_IDLE: if (job_valid_i) state_d = pcc_pkg::BK_LOAD;
      pcc_pkg::BK_LOAD: state_d = pcc_pkg::BK_MUL;
      pcc_pkg::BK_MUL: begin
        if (mul_done) begin
          if (op_q == pcc_pkg::MO_XY && (job_q.overflowed || zero_var)) begin
            state_d = pcc_pkg::BK_DONE;
          end else if (op_q == pcc_pkg::MO_NUM) begin
            state_d = pcc_pkg::BK_DIV;
          end else begin
            state_d = pcc_pkg::BK_LOAD;
          end
        end
      end
      pcc_pkg::BK_DIV:  if (cnt_q == 5'd0) state_d = pcc_pkg::BK_SQRT;
      pcc_pkg::BK_SQRT: if (cnt_q == 5'd0) state_d = pcc_pkg::BK_DONE;
      pcc_pkg::BK_DONE: if (out_free) state_d = pcc_pkg::BK_IDLE;
      default:          state_d = pcc_pkg::BK_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    job_pop_o = 1'b0;
    load_out  = 1'b0;
    op_d      = op_q;
    mc_d      = mc_q;
    mp_d      = mp_q;
    acc_d     = acc_q;
    t0_d      = t0_q;
    dx_d      = dx_q;
    dy_d      = dy_q;
    num_d     = num_q;
    rem_d     = rem_q;
    dv_d      = dv_q;
    quo_d     = quo_q;
    root_d    = root_q;
    cnt_d     = cnt_q;
    status_d  = status_q;
    out_d     = out_q;
    case (state_q)
      pcc_pkg::BK_IDLE: begin
        job_pop_o = job_valid_i;
        op_d      = pcc_pkg::MO_NXX;
      end
      pcc_pkg::BK_LOAD: begin
        mc_d  = op_a;
        mp_d  = op_b;
        acc_d = '0;
      end
      pcc_pkg::BK_MUL: begin
        if (!mul_done) begin
          acc_d = acc_q + (mp_q[0] ? mc_q : 128'd0);
          mc_d  = {mc_q[126:0], 1'b0};
          mp_d  = {1'b0, mp_q[63:1]};
        end else begin
          op_d = pcc_pkg::mul_op_e'(op_q + 3'd1);
          case (op_q)
            pcc_pkg::MO_NXX, pcc_pkg::MO_NYY, pcc_pkg::MO_VAR: t0_d = acc_q;
            pcc_pkg::MO_XX:  dx_d = 63'(t0_q - acc_q);
            pcc_pkg::MO_YY:  dy_d = 63'(t0_q - acc_q);
            pcc_pkg::MO_NXY: num_d = job_q.sum_xy[47] ? -$signed(prod_s) : $signed(prod_s);
            pcc_pkg::MO_XY: begin
              num_d = (job_q.sum_x[32] ^ job_q.sum_y[32]) ? num_q + $signed(prod_s)
                                                            : num_q - $signed(prod_s);
              if (job_q.overflowed)  status_d = pcc_pkg::STATUS_OVERFLOW;
              else if (zero_var)     status_d = pcc_pkg::STATUS_ZERO_VAR;
              else                   status_d = pcc_pkg::STATUS_OK;
            end
            pcc_pkg::MO_NUM: begin
              rem_d = {2'b00, acc_q, 30'd0};
              dv_d  = {2'b00, t0_q, 30'd0};
              quo_d = '0;
              cnt_d = 5'd30;
            end
            default: t0_d = t0_q;
          endcase
        end
      end
      pcc_pkg::BK_DIV: begin
        if (rem_ge) rem_d = rem_q - dv_q;
        quo_d = {quo_q[29:0], rem_ge};
        dv_d  = {1'b0, dv_q[159:1]};
        if (cnt_q == 5'd0) begin
          cnt_d  = 5'd15;
          root_d = '0;
        end else begin
          cnt_d = cnt_q - 5'd1;
        end
      end
      pcc_pkg::BK_SQRT: begin
        if (cand_sq <= {1'b0, quo_q}) root_d = cand;
        cnt_d = cnt_q - 5'd1;
      end
      pcc_pkg::BK_DONE: begin
        load_out = out_free;
        out_d.status     = status_q;
        out_d.pair_count = job_q.count;
        if (status_q != pcc_pkg::STATUS_OK) begin
          out_d.coefficient_q15 = '0;
        end else if (num_q[65]) begin
          out_d.coefficient_q15 = -$signed(root_q);
        end else if (root_q[15]) begin
          out_d.coefficient_q15 = 16'sd32767;
        end else begin
          out_d.coefficient_q15 = $signed(root_q);
        end
      end
      default: op_d = op_q;
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (load_out)                      out_vld_d = 1'b1;
    else if (out_vld_q && !out_stall_i) out_vld_d = 1'b0;
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= pcc_pkg::BK_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) job_q <= job_i;
    if (load_out)  out_q <= out_d;
    op_q     <= op_d;
    mc_q     <= mc_d;
    mp_q     <= mp_d;
    acc_q    <= acc_d;
    t0_q     <= t0_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    dv_q     <= dv_d;
    quo_q    <= quo_d;
    root_q   <= root_d;
    cnt_q    <= cnt_d;
    status_q <= status_d;
  end

endmodule

### rtl/pearson_correlation_unit.sv
`timescale 1ns / 1ps
// Throughput: one pair per cycle while a set accumulates; the accumulator only
//   stalls when two finished sets wait in the job queue.
// Flow: the finished set is registered in the job queue before the solver
//   takes it; result valid follows up to eight shift-add products and, for a
//   valid set, 31 division steps and 16 root steps.
// Reset: asynchronous, active low; clears sums, queue and output valid.
// ----------------------------------------------------------------------------
// pearson_correlation_unit
// Streaming Pearson coefficient in Q1.15 over sets of paired samples.
// ----------------------------------------------------------------------------
module pearson_correlation_unit #(
  parameter int MAX_SAMPLES = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  pcc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output pcc_pkg::out_item_t out_item_o
);

  logic          push, q_full, q_valid, pop;
  pcc_pkg::job_t job_in, job_out;

  // Front: accumulate exact sums, push the finished set.
  pcc_front #(
    .MAX_SAMPLES(MAX_SAMPLES),
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .in_item_i (in_item_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .job_o     (job_in)
  );

  // Hold up to two sets so accumulation runs on while the solver works.
  pcc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .job_o  (job_out)
  );

  // Back: form variances and covariance, divide, take the root.
  pcc_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(q_valid),
    .job_i      (job_out),
    .job_pop_o  (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

endmodule

### rtl/pcc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcc_checker
// Port-level checks for the Pearson correlation unit.
// ----------------------------------------------------------------------------
module pcc_checker #(
  parameter int MAX_SAMPLES = 65536
) (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input pcc_pkg::out_item_t out_item_o
);

  localparam logic [16:0] MaxCnt = 17'(MAX_SAMPLES);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled result changed or dropped");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_item_o.status == pcc_pkg::STATUS_OK ||
                    out_item_o.status == pcc_pkg::STATUS_ZERO_VAR ||
                    out_item_o.status == pcc_pkg::STATUS_OVERFLOW)
    else $error("bad status code");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status != pcc_pkg::STATUS_OK |->
      out_item_o.coefficient_q15 == 16'sd0)
    else $error("error result carries a coefficient");

  a_ovf_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.status == pcc_pkg::STATUS_OVERFLOW |->
      out_item_o.pair_count == MaxCnt)
    else $error("overflow set without full count");

  // The job queue is empty right after reset, so the input must be open.
  a_in_open_after_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !in_stall_o)
    else $error("input stalled right after reset");

endmodule

bind pearson_correlation_unit pcc_checker #(
  .MAX_SAMPLES(MAX_SAMPLES)
) u_pcc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_stall_o (in_stall_o),
  .out_valid_o(out_valid_o),
  .out_stall_i(out_stall_i),
  .out_item_o (out_item_o)
);
